### rtl/core/stfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stfl_pkg;

  // Table geometry. The slot and count widths below follow from MAX_SLOTS.
  localparam int MAX_SLOTS = 1024;
  localparam int VALUE_W   = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GROW   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_MODE     = 3'd3,
    ST_SHRINK   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_GROW
  } state_t;

  // One word of the link memory: the occupancy flag and the free-list link.
  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    link_t             data;
  } link_wr_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } store_wr_t;

endpackage

`default_nettype wire

### rtl/core/stfl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stfl_req_if;
  logic                       valid;
  logic                       ready;
  logic [stfl_pkg::OP_W-1:0]  opcode;
  logic [stfl_pkg::VALUE_W-1:0] entry_value;
  logic [stfl_pkg::SLOT_W-1:0] slot_index;
  logic [stfl_pkg::CNT_W-1:0] new_capacity;

  modport source (output valid, opcode, entry_value, slot_index, new_capacity,
                  input ready);
  modport sink (input valid, opcode, entry_value, slot_index, new_capacity,
                output ready);
endinterface

interface stfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [stfl_pkg::SLOT_W-1:0]   assigned_slot;
  logic [stfl_pkg::VALUE_W-1:0]  removed_value;
  logic [stfl_pkg::SLOT_W-1:0]   moved_from;
  logic [stfl_pkg::SLOT_W-1:0]   moved_to;
  logic [stfl_pkg::CNT_W-1:0]    live_count;
  logic [stfl_pkg::STATUS_W-1:0] status;

  modport source (output valid, assigned_slot, removed_value, moved_from, moved_to,
                  live_count, status, input ready);
  modport sink (input valid, assigned_slot, removed_value, moved_from, moved_to,
                live_count, status, output ready);
endinterface

`default_nettype wire

### rtl/core/stfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write and one registered read per cycle.
module stfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/stfl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: issues the memory reads, checks the request against the
// returned words, writes the table back and holds the response register.
module stfl_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         compact_mode,
  stfl_req_if.sink                          req,
  stfl_rsp_if.source                        rsp,
  output stfl_pkg::mem_rd_t                 link_rd,
  output stfl_pkg::mem_rd_t                 store_rd,
  input  wire stfl_pkg::link_t              link_rdata,
  input  wire logic [stfl_pkg::VALUE_W-1:0] store_rdata,
  output stfl_pkg::link_wr_t                link_wr,
  output stfl_pkg::store_wr_t               store_wr
);

  localparam int SW = stfl_pkg::SLOT_W;
  localparam int CW = stfl_pkg::CNT_W;
  localparam int VW = stfl_pkg::VALUE_W;

  stfl_pkg::state_t state, state_next;

  logic [CW-1:0] free_head, free_head_next;
  logic [CW-1:0] capacity, capacity_next;
  logic [CW-1:0] entry_count, entry_count_next;

  // Latched request.
  stfl_pkg::op_t op_q;
  logic [VW-1:0] val_q;
  logic [SW-1:0] ix_q;
  logic [CW-1:0] ncap_q;
  logic [CW-1:0] ncap_in;

  logic [CW-1:0] grow_idx;
  logic [CW-1:0] grow_idx_inc;
  logic          grow_last;
  logic          grow_step;
  logic [VW-1:0] rem_val_q;

  // Response register.
  logic                   out_valid;
  logic [SW-1:0]          out_slot, out_from, out_to;
  logic [VW-1:0]          out_removed;
  logic [CW-1:0]          out_live;
  stfl_pkg::status_t      out_status;

  logic                   push, fire, accept, out_free;
  logic [SW-1:0]          res_slot, res_from, res_to;
  logic [VW-1:0]          res_removed;
  stfl_pkg::status_t      res_status;

  logic          ins_fail, rem_fail, grow_mode_fail, grow_shrink, grow_walk;
  logic [CW-1:0] ix_wide, end_slot;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign fire     = push && out_free;

  assign ncap_in = (req.new_capacity > CW'(stfl_pkg::MAX_SLOTS)) ?
                   CW'(stfl_pkg::MAX_SLOTS) : req.new_capacity;

  assign ix_wide  = CW'(ix_q);
  assign end_slot = entry_count - CW'(1);

  assign ins_fail = (entry_count >= capacity) || (free_head >= capacity) || link_rdata.used;
  assign rem_fail = (ix_wide >= capacity) || !link_rdata.used || (entry_count == '0) ||
                    (compact_mode && (ix_wide >= entry_count));
  assign grow_mode_fail = compact_mode && (entry_count != capacity);
  assign grow_shrink    = ncap_q < capacity;
  assign grow_walk      = ncap_q > capacity;

  assign grow_idx_inc = grow_idx + CW'(1);
  assign grow_last    = (grow_idx_inc == ncap_q);
  assign grow_step    = (state == stfl_pkg::S_GROW) && (!grow_last || out_free);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stfl_pkg::S_IDLE: begin
        if (accept) begin
          state_next = stfl_pkg::S_EXEC;
        end
      end
      stfl_pkg::S_EXEC: begin
        if ((op_q == stfl_pkg::OP_REMOVE) && !rem_fail && compact_mode) begin
          state_next = stfl_pkg::S_MOVE;
        end else if ((op_q == stfl_pkg::OP_GROW) && !grow_mode_fail && !grow_shrink &&
                     grow_walk) begin
          state_next = stfl_pkg::S_GROW;
        end else if (out_free) begin
          state_next = stfl_pkg::S_IDLE;
        end
      end
      stfl_pkg::S_MOVE: begin
        if (out_free) begin
          state_next = stfl_pkg::S_IDLE;
        end
      end
      stfl_pkg::S_GROW: begin
        if (grow_last && out_free) begin
          state_next = stfl_pkg::S_IDLE;
        end
      end
      default: state_next = stfl_pkg::S_IDLE;
    endcase
  end

  // Memory commands, response fields and next register values.
  always_comb begin
    req.ready        = 1'b0;
    link_rd          = '0;
    store_rd         = '0;
    link_wr          = '0;
    store_wr         = '0;
    push             = 1'b0;
    res_slot         = '0;
    res_removed      = '0;
    res_from         = '0;
    res_to           = '0;
    res_status       = stfl_pkg::ST_OK;
    free_head_next   = free_head;
    capacity_next    = capacity;
    entry_count_next = entry_count;
    unique case (state)
      stfl_pkg::S_IDLE: begin
        // Ready is always high here, so a valid request is taken this cycle.
        req.ready     = 1'b1;
        link_rd.re    = req.valid;
        link_rd.addr  = (stfl_pkg::op_t'(req.opcode) == stfl_pkg::OP_INSERT) ?
                        free_head[SW-1:0] : req.slot_index;
        store_rd.re   = req.valid;
        store_rd.addr = req.slot_index;
      end
      stfl_pkg::S_EXEC: begin
        unique case (op_q)
          stfl_pkg::OP_INSERT: begin
            push = 1'b1;
            if (ins_fail) begin
              res_status = stfl_pkg::ST_FULL;
            end else begin
              res_slot         = free_head[SW-1:0];
              store_wr         = '{we: 1'b1, addr: free_head[SW-1:0], data: val_q};
              link_wr          = '{we: 1'b1, addr: free_head[SW-1:0],
                                   data: '{used: 1'b1, next: link_rdata.next}};
              free_head_next   = link_rdata.next;
              entry_count_next = entry_count + CW'(1);
            end
          end
          stfl_pkg::OP_REMOVE: begin
            if (rem_fail) begin
              push       = 1'b1;
              res_status = stfl_pkg::ST_BAD_SLOT;
            end else if (!compact_mode) begin
              push             = 1'b1;
              res_removed      = store_rdata;
              link_wr          = '{we: 1'b1, addr: ix_q,
                                   data: '{used: 1'b0, next: free_head}};
              free_head_next   = ix_wide;
              entry_count_next = end_slot;
            end else begin
              // Fetch the last live entry; the gap is filled in the next step.
              store_rd = '{re: 1'b1, addr: end_slot[SW-1:0]};
            end
          end
          stfl_pkg::OP_GROW: begin
            if (grow_mode_fail) begin
              push       = 1'b1;
              res_status = stfl_pkg::ST_MODE;
            end else if (grow_shrink) begin
              push       = 1'b1;
              res_status = stfl_pkg::ST_SHRINK;
            end else if (!grow_walk) begin
              push = 1'b1;
            end
          end
          default: begin
            push = 1'b1;
          end
        endcase
      end
      stfl_pkg::S_MOVE: begin
        push             = 1'b1;
        res_removed      = rem_val_q;
        res_from         = end_slot[SW-1:0];
        res_to           = ix_q;
        store_wr         = '{we: 1'b1, addr: ix_q, data: store_rdata};
        link_wr          = '{we: 1'b1, addr: end_slot[SW-1:0],
                             data: '{used: 1'b0, next: free_head}};
        free_head_next   = end_slot;
        entry_count_next = end_slot;
      end
      stfl_pkg::S_GROW: begin
        link_wr = '{we: 1'b1, addr: grow_idx[SW-1:0],
                    data: '{used: 1'b0, next: (grow_last ? free_head : grow_idx_inc)}};
        if (grow_last) begin
          push           = 1'b1;
          free_head_next = capacity;
          capacity_next  = ncap_q;
        end
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
    // A finished request waits here until the response register frees up.
    if (push && !out_free) begin
      link_wr.we  = 1'b0;
      store_wr.we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stfl_pkg::S_IDLE;
      free_head   <= CW'(stfl_pkg::MAX_SLOTS);
      capacity    <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        free_head   <= free_head_next;
        capacity    <= capacity_next;
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= stfl_pkg::op_t'(req.opcode);
      val_q  <= req.entry_value;
      ix_q   <= req.slot_index;
      ncap_q <= ncap_in;
    end
    if ((state == stfl_pkg::S_EXEC) && (state_next == stfl_pkg::S_GROW)) begin
      grow_idx <= capacity;
    end else if (grow_step) begin
      grow_idx <= grow_idx_inc;
    end
    if ((state == stfl_pkg::S_EXEC) && (state_next == stfl_pkg::S_MOVE)) begin
      rem_val_q <= store_rdata;
    end
    if (fire) begin
      out_slot    <= res_slot;
      out_removed <= res_removed;
      out_from    <= res_from;
      out_to      <= res_to;
      out_live    <= entry_count_next;
      out_status  <= res_status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.assigned_slot = out_slot;
  assign rsp.removed_value = out_removed;
  assign rsp.moved_from    = out_from;
  assign rsp.moved_to      = out_to;
  assign rsp.live_count    = out_live;
  assign rsp.status        = out_status;

endmodule

`default_nettype wire

### rtl/core/slot_table_free_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot table with a linked free list. Each request inserts a value into the
// slot at the head of the free list, removes a slot (pushing it back on the
// free list, or in compact mode moving the last live entry into the gap), or
// grows the capacity by linking the new slots in ascending order in front of
// the free list; each request produces exactly one response carrying the
// assigned slot, the removed value, the move report, the live count and a
// status code. Values live in a 1024 x 32 synchronous RAM and the occupancy
// flag plus free-list link of every slot live in a second 1024 x 12 RAM, both
// with a registered read. Requests are handled one at a time: insert and plain
// remove read the RAMs, then check and write back; compact remove adds a move
// step because the value RAM has one read port and must also fetch the last
// live entry; a grow that adds N slots writes one link word per new slot. A
// response waiting in the output register does not block the next request
// from being accepted; it only delays the write-back of that request. There is
// no clearing pass after reset: a slot only becomes readable once a grow has
// brought it below the capacity, and the grow writes its link word, so stale
// RAM contents are never used. The compact_mode register is written through
// cfg_we and cfg_wdata and should change only while no request is in flight.
module slot_table_free_list (
  input  wire logic  clk,
  input  wire logic  rst,
  stfl_req_if.sink   req,
  stfl_rsp_if.source rsp,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  localparam int LINK_W = $bits(stfl_pkg::link_t);

  logic                        compact_mode;
  stfl_pkg::mem_rd_t           link_rd, store_rd;
  stfl_pkg::link_wr_t          link_wr;
  stfl_pkg::store_wr_t         store_wr;
  logic [LINK_W-1:0]           link_rdata_raw;
  stfl_pkg::link_t             link_rdata;
  logic [stfl_pkg::VALUE_W-1:0] store_rdata;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      compact_mode <= 1'b0;
    end else if (cfg_we) begin
      compact_mode <= cfg_wdata;
    end
  end

  assign link_rdata = stfl_pkg::link_t'(link_rdata_raw);

  stfl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .compact_mode (compact_mode),
    .req          (req),
    .rsp          (rsp),
    .link_rd      (link_rd),
    .store_rd     (store_rd),
    .link_rdata   (link_rdata),
    .store_rdata  (store_rdata),
    .link_wr      (link_wr),
    .store_wr     (store_wr)
  );

  // Occupancy flags and free-list links.
  stfl_ram #(
    .DEPTH (stfl_pkg::MAX_SLOTS),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .re    (link_rd.re),
    .raddr (link_rd.addr),
    .rdata (link_rdata_raw),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data)
  );

  // Stored values.
  stfl_ram #(
    .DEPTH (stfl_pkg::MAX_SLOTS),
    .WIDTH (stfl_pkg::VALUE_W)
  ) u_store_ram (
    .clk   (clk),
    .re    (store_rd.re),
    .raddr (store_rd.addr),
    .rdata (store_rdata),
    .we    (store_wr.we),
    .waddr (store_wr.addr),
    .wdata (store_wr.data)
  );

endmodule

`default_nettype wire

### rtl/core/stfl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stfl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [stfl_pkg::SLOT_W-1:0]   assigned_slot,
  input wire logic [stfl_pkg::VALUE_W-1:0]  removed_value,
  input wire logic [stfl_pkg::SLOT_W-1:0]   moved_from,
  input wire logic [stfl_pkg::SLOT_W-1:0]   moved_to,
  input wire logic [stfl_pkg::CNT_W-1:0]    live_count,
  input wire logic [stfl_pkg::STATUS_W-1:0] status
);

  // Requests are handled one at a time, so ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  // A failed request reports no slot, value or move.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != stfl_pkg::ST_OK)) |->
    ((assigned_slot == '0) && (removed_value == '0) && (moved_from == '0) &&
     (moved_to == '0)))
    else $error("failed request carries payload");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((live_count <= stfl_pkg::CNT_W'(stfl_pkg::MAX_SLOTS)) &&
                   (status <= stfl_pkg::ST_SHRINK)))
    else $error("live count or status out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(live_count) && $stable(status)))
    else $error("stalled response changed");

endmodule

bind slot_table_free_list stfl_checker u_stfl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .assigned_slot (rsp.assigned_slot),
  .removed_value (rsp.removed_value),
  .moved_from    (rsp.moved_from),
  .moved_to      (rsp.moved_to),
  .live_count    (rsp.live_count),
  .status        (rsp.status)
);

`default_nettype wire
